[design/cac_pkg.sv]
// Shared constants and types for the canopy aerodynamic conductance core.
package cac_pkg;

  localparam int HGT_W     = 16;
  localparam int SPD_W     = 16;
  localparam int CND_W     = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int MANT_BITS = 30;
  localparam int NUM_W     = 26;
  localparam int DEN_W     = 24;
  localparam int GNUM_W    = 27;
  localparam int KW        = 5;

  localparam logic [63:0]      LN2_Q64  = 64'hB17217F7D1CF79AB;
  localparam logic [CND_W-1:0] OUT_MAX  = '1;
  localparam logic [HGT_W-1:0] MEAS_RST = 16'd5000;

  // floor(2^29 / 100), used for the height limit
  localparam logic [22:0] RECIP_100 = 23'd5368709;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAS_HEIGHT = 1'b0,
    CFG_MIN_COND    = 1'b1
  } cfg_idx_t;

endpackage

[design/cac_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with side data.
module cac_div import cac_pkg::*; #(
  parameter int NW = 42,
  parameter int DW = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [0:NW-1];
  logic [NW-1:0] num_r  [0:NW-1];
  logic [DW-1:0] rem_r  [0:NW-1];
  logic [DW-1:0] den_r  [0:NW-1];
  logic [SW-1:0] side_r [0:NW-1];

  logic          l_vld  [0:NW-1];
  logic [NW-1:0] l_num  [0:NW-1];
  logic [DW-1:0] l_rem  [0:NW-1];
  logic [DW-1:0] l_den  [0:NW-1];
  logic [SW-1:0] l_side [0:NW-1];

  logic [NW-1:0] num_nxt [0:NW-1];
  logic [DW-1:0] rem_nxt [0:NW-1];

  always_comb begin
    l_vld[0]  = in_valid;
    l_num[0]  = in_num;
    l_rem[0]  = '0;
    l_den[0]  = in_den;
    l_side[0] = in_side;
    for (int s = 1; s < NW; s++) begin
      l_vld[s]  = vld_r[s-1];
      l_num[s]  = num_r[s-1];
      l_rem[s]  = rem_r[s-1];
      l_den[s]  = den_r[s-1];
      l_side[s] = side_r[s-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    trial = '0;
    for (int s = 0; s < NW; s++) begin
      trial = {l_rem[s], l_num[s][NW-1]};
      if (trial >= {1'b0, l_den[s]}) begin
        rem_nxt[s] = DW'(trial - {1'b0, l_den[s]});
        num_nxt[s] = {l_num[s][NW-2:0], 1'b1};
      end else begin
        rem_nxt[s] = trial[DW-1:0];
        num_nxt[s] = {l_num[s][NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NW; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < NW; s++) vld_r[s] <= l_vld[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        num_r[s]  <= num_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        den_r[s]  <= l_den[s];
        side_r[s] <= l_side[s];
      end
    end
  end

  assign out_valid = vld_r[NW-1];
  assign out_quo   = num_r[NW-1];
  assign out_side  = side_r[NW-1];

endmodule

[design/cac_ln.sv]
// Pipelined natural log of a fixed-point ratio by normalize and repeated squaring.
module cac_ln import cac_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int QW        = 42,
  parameter int SW        = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [QW-1:0]          in_q,
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  output logic [FRAC_BITS+KW-1:0] out_ln,
  output logic [SW-1:0]          out_side
);

  localparam int LW  = FRAC_BITS + KW;
  localparam int MBW = $clog2(QW);
  localparam int MW  = MANT_BITS + 1;
  localparam int F   = FRAC_BITS;

  // leading one
  logic [MBW-1:0] msb;
  logic           below_one;

  always_comb begin
    msb = '0;
    for (int i = 0; i < QW; i++) begin
      if (in_q[i]) msb = MBW'(i);
    end
  end
  assign below_one = ((in_q >> F) == '0);

  logic           a_vld_r;
  logic [QW-1:0]  a_q_r;
  logic [MBW-1:0] a_msb_r;
  logic           a_small_r;
  logic [SW-1:0]  a_side_r;

  // normalize to Q30
  logic [QW+MANT_BITS-1:0] shx;
  assign shx = {a_q_r, {MANT_BITS{1'b0}}} >> a_msb_r;

  logic          b_vld_r;
  logic [MW-1:0] b_m_r;
  logic [KW-1:0] b_k_r;
  logic          b_small_r;
  logic [SW-1:0] b_side_r;

  // squaring chain
  logic          s_vld_r   [0:F-1];
  logic [MW-1:0] s_m_r     [0:F-1];
  logic [F-1:0]  s_fr_r    [0:F-1];
  logic [KW-1:0] s_k_r     [0:F-1];
  logic          s_small_r [0:F-1];
  logic [SW-1:0] s_side_r  [0:F-1];

  logic          l_vld   [0:F-1];
  logic [MW-1:0] l_m     [0:F-1];
  logic [F-1:0]  l_fr    [0:F-1];
  logic [KW-1:0] l_k     [0:F-1];
  logic          l_small [0:F-1];
  logic [SW-1:0] l_side  [0:F-1];

  logic [MW-1:0] m_nxt  [0:F-1];
  logic [F-1:0]  fr_nxt [0:F-1];

  always_comb begin
    l_vld[0]   = b_vld_r;
    l_m[0]     = b_m_r;
    l_fr[0]    = '0;
    l_k[0]     = b_k_r;
    l_small[0] = b_small_r;
    l_side[0]  = b_side_r;
    for (int s = 1; s < F; s++) begin
      l_vld[s]   = s_vld_r[s-1];
      l_m[s]     = s_m_r[s-1];
      l_fr[s]    = s_fr_r[s-1];
      l_k[s]     = s_k_r[s-1];
      l_small[s] = s_small_r[s-1];
      l_side[s]  = s_side_r[s-1];
    end
  end

  always_comb begin
    logic [2*MW-1:0] sq;
    logic [MW:0]     m2;
    sq = '0;
    m2 = '0;
    for (int s = 0; s < F; s++) begin
      sq = l_m[s] * l_m[s];
      m2 = sq[2*MW-1:MANT_BITS];
      if (m2[MW]) begin
        m_nxt[s]  = m2[MW:1];
        fr_nxt[s] = {l_fr[s][F-2:0], 1'b1};
      end else begin
        m_nxt[s]  = m2[MW-1:0];
        fr_nxt[s] = {l_fr[s][F-2:0], 1'b0};
      end
    end
  end

  // log2 to ln
  logic [LW-1:0] log2q;
  assign log2q = s_small_r[F-1] ? '0 : {s_k_r[F-1], s_fr_r[F-1]};

  logic           c_vld_r;
  logic [LW+31:0] c_lo_r;
  logic [LW+31:0] c_hi_r;
  logic [SW-1:0]  c_side_r;

  logic [LW+32:0] ln_sum;
  assign ln_sum = {1'b0, c_hi_r} + (LW+33)'(c_lo_r >> 32);

  logic          d_vld_r;
  logic [LW-1:0] d_ln_r;
  logic [SW-1:0] d_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      for (int s = 0; s < F; s++) s_vld_r[s] <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      for (int s = 0; s < F; s++) s_vld_r[s] <= l_vld[s];
      c_vld_r <= s_vld_r[F-1];
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q_r     <= in_q;
      a_msb_r   <= msb;
      a_small_r <= below_one;
      a_side_r  <= in_side;
      b_m_r     <= shx[MW-1:0];
      b_k_r     <= a_small_r ? '0 : KW'(int'(a_msb_r) - F);
      b_small_r <= a_small_r;
      b_side_r  <= a_side_r;
      for (int s = 0; s < F; s++) begin
        s_m_r[s]     <= m_nxt[s];
        s_fr_r[s]    <= fr_nxt[s];
        s_k_r[s]     <= l_k[s];
        s_small_r[s] <= l_small[s];
        s_side_r[s]  <= l_side[s];
      end
      c_lo_r   <= log2q * LN2_Q64[31:0];
      c_hi_r   <= log2q * LN2_Q64[63:32];
      c_side_r <= s_side_r[F-1];
      d_ln_r   <= LW'(ln_sum >> 32);
      d_side_r <= c_side_r;
    end
  end

  assign out_valid = d_vld_r;
  assign out_ln    = d_ln_r;
  assign out_side  = d_side_r;

endmodule

[design/canopy_aerodynamic_conductance_core.sv]
// Canopy aerodynamic conductance core: fully pipelined, one item per clock unless the pipe
// is frozen. in_stall is high only while a result sits in the output register and
// out_stall holds it; the whole pipe then freezes. The height limit is derived from the
// measurement height through the registers lx_r, lq_r and lim_r after a write.
module canopy_aerodynamic_conductance_core import cac_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [HGT_W-1:0]     in_canopy_height_mm,
  input  logic [SPD_W-1:0]     in_wind_speed_mm_s,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CND_W-1:0]     out_conductance_um_s
);

  localparam int F   = FRAC_BITS;
  localparam int QW  = NUM_W + F;
  localparam int LW  = F + KW;
  localparam int PW  = F + 10;
  localparam int GDW = F + 14;
  localparam int GNW = GNUM_W + F;

  logic en;

  // configuration
  logic [HGT_W-1:0] meas_r;
  logic [CND_W-1:0] min_r;
  logic [22:0]      lx_r;
  logic [16:0]      lq_r;
  logic [HGT_W-1:0] lim_r;
  logic [NUM_W-1:0] z1000_r;
  logic [22:0]      lx_nxt;
  logic [45:0]      lprod;
  logic [22:0]      lrem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r <= MEAS_RST;
      min_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MEAS_HEIGHT: meas_r <= cfg_data[HGT_W-1:0];
        CFG_MIN_COND:    min_r  <= cfg_data[CND_W-1:0];
        default: ;
      endcase
    end
  end

  assign lx_nxt = 23'(meas_r * 98);
  assign lprod  = lx_nxt * RECIP_100;
  assign lrem   = 23'(lx_r - 23'(lq_r * 100));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r    <= 23'd490000;
      lq_r    <= 17'd4900;
      lim_r   <= 16'd4900;
      z1000_r <= 26'd5000000;
    end else begin
      lx_r    <= lx_nxt;
      lq_r    <= lprod[45:29];
      lim_r   <= (lrem >= 23'd100) ? HGT_W'(lq_r + 17'd1) : lq_r[HGT_W-1:0];
      z1000_r <= NUM_W'(meas_r * 1000);
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: clamp height
  logic             s1_vld_r;
  logic [HGT_W-1:0] s1_h_r;
  logic [SPD_W-1:0] s1_v_r;

  // stage 2: ratio terms
  logic             s2_vld_r;
  logic [NUM_W-1:0] s2_n1_r, s2_n2_r;
  logic [DEN_W-1:0] s2_d1_r, s2_d2_r;
  logic [SPD_W-1:0] s2_v_r;
  logic             s2_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_h_r    <= (in_canopy_height_mm > lim_r) ? lim_r : in_canopy_height_mm;
      s1_v_r    <= in_wind_speed_mm_s;
      s2_n1_r   <= NUM_W'(z1000_r - NUM_W'(s1_h_r * 744));
      s2_n2_r   <= NUM_W'(z1000_r - NUM_W'(s1_h_r * 640));
      s2_d1_r   <= DEN_W'(s1_h_r * 26);
      s2_d2_r   <= DEN_W'(s1_h_r * 130);
      s2_v_r    <= s1_v_r;
      s2_zero_r <= (s1_h_r == '0);
    end
  end

  // ratio dividers
  logic             q1_vld, q2_vld;
  logic [QW-1:0]    q1, q2;
  logic [SPD_W-1:0] q1_v;
  logic             q2_zero;

  cac_div #(.NW(QW), .DW(DEN_W), .SW(SPD_W)) u_div1 (
    .clk, .rst_n, .en,
    .in_valid (s2_vld_r),
    .in_num   ({s2_n1_r, {F{1'b0}}}),
    .in_den   (s2_d1_r),
    .in_side  (s2_v_r),
    .out_valid(q1_vld),
    .out_quo  (q1),
    .out_side (q1_v)
  );

  cac_div #(.NW(QW), .DW(DEN_W), .SW(1)) u_div2 (
    .clk, .rst_n, .en,
    .in_valid (s2_vld_r),
    .in_num   ({s2_n2_r, {F{1'b0}}}),
    .in_den   (s2_d2_r),
    .in_side  (s2_zero_r),
    .out_valid(q2_vld),
    .out_quo  (q2),
    .out_side (q2_zero)
  );

  // logs
  logic             l1_vld, l2_vld;
  logic [LW-1:0]    ln1, ln2;
  logic [SPD_W-1:0] l1_v;
  logic             l2_zero;

  cac_ln #(.FRAC_BITS(F), .QW(QW), .SW(SPD_W)) u_ln1 (
    .clk, .rst_n, .en,
    .in_valid (q1_vld),
    .in_q     (q1),
    .in_side  (q1_v),
    .out_valid(l1_vld),
    .out_ln   (ln1),
    .out_side (l1_v)
  );

  cac_ln #(.FRAC_BITS(F), .QW(QW), .SW(1)) u_ln2 (
    .clk, .rst_n, .en,
    .in_valid (q2_vld),
    .in_q     (q2),
    .in_side  (q2_zero),
    .out_valid(l2_vld),
    .out_ln   (ln2),
    .out_side (l2_zero)
  );

  // product, then final divider operands
  logic              p_vld_r;
  logic [2*LW-1:0]   p_prod_r;
  logic [SPD_W-1:0]  p_v_r;
  logic              p_zero_r;
  logic [PW-1:0]     p_val;

  logic              g_vld_r;
  logic [GNW-1:0]    g_num_r;
  logic [GDW-1:0]    g_den_r;
  logic [1:0]        g_flag_r;

  assign p_val = p_prod_r[F+PW-1:F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= l1_vld;
      g_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod_r <= ln1 * ln2;
      p_v_r    <= l1_v;
      p_zero_r <= l2_zero;
      g_num_r  <= {GNUM_W'(p_v_r * 1681), {F{1'b0}}};
      g_den_r  <= GDW'({p_val, 3'b000}) + GDW'({p_val, 1'b0});
      g_flag_r <= {p_zero_r, (p_val == '0)};
    end
  end

  logic           gq_vld;
  logic [GNW-1:0] gq;
  logic [1:0]     gq_flag;

  cac_div #(.NW(GNW), .DW(GDW), .SW(2)) u_div3 (
    .clk, .rst_n, .en,
    .in_valid (g_vld_r),
    .in_num   (g_num_r),
    .in_den   (g_den_r),
    .in_side  (g_flag_r),
    .out_valid(gq_vld),
    .out_quo  (gq),
    .out_side (gq_flag)
  );

  // clamp and output register
  logic [CND_W-1:0] g_sat, g_fin;
  logic             out_valid_r;
  logic [CND_W-1:0] out_cond_r;

  always_comb begin
    if (gq_flag[1]) begin
      g_sat = '0;
    end else if (gq_flag[0] || (gq[GNW-1:CND_W] != '0)) begin
      g_sat = OUT_MAX;
    end else begin
      g_sat = gq[CND_W-1:0];
    end
    g_fin = (g_sat < min_r) ? min_r : g_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= gq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cond_r <= g_fin;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_conductance_um_s = out_cond_r;

  a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n) q1_vld == q2_vld)
    else $error("ratio divider lanes out of step");

  a_ln_lanes: assert property (@(posedge clk) disable iff (!rst_n) l1_vld == l2_vld)
    else $error("log lanes out of step");

  a_min_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cond_r >= min_r))
    else $error("result below minimum conductance");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(gq) && $stable(out_cond_r))
    else $error("pipeline moved during a stalled transfer");

endmodule

[dv/cac_checker.sv]
// Checker for the canopy conductance core: predicts each result and compares it.
module cac_checker import cac_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [HGT_W-1:0]     in_canopy_height_mm,
  input  logic [SPD_W-1:0]     in_wind_speed_mm_s,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CND_W-1:0]     out_conductance_um_s,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);

  logic [HGT_W-1:0] meas_height;
  logic [CND_W-1:0] min_cond;
  logic [CND_W-1:0] expected_cond_q[$];

  function automatic longint unsigned ln_of_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q, m, frac, log2q;
    logic [127:0] wide;
    int msb, k;
    frac = 0;
    msb = 0;
    if (den == 0) return 0;
    q = (num << FRAC_BITS) / den;
    if (q < (64'd1 << FRAC_BITS)) return 0;
    for (int i = 0; i < 64; i++) if (q[i]) msb = i;
    k = msb - FRAC_BITS;
    if (msb > MANT_BITS) m = q >> (msb - MANT_BITS);
    else m = q << (MANT_BITS - msb);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> MANT_BITS;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_BITS)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    log2q = (longint'(k) << FRAC_BITS) | frac;
    wide = 128'(log2q) * 128'(LN2_Q64);
    return wide[127:64];
  endfunction

  function automatic logic [CND_W-1:0] predict_conductance(logic [HGT_W-1:0] h,
                                                           logic [SPD_W-1:0] v);
    longint unsigned z, lim, he, l1, l2, p, g;
    logic [127:0] wide;
    z = meas_height;
    lim = (98 * z) / 100;
    he = (h > lim) ? lim : h;
    g = 0;
    if (he != 0) begin
      l1 = ln_of_ratio(1000 * z - 744 * he, 26 * he);
      l2 = ln_of_ratio(1000 * z - 640 * he, 130 * he);
      wide = 128'(l1) * 128'(l2);
      p = 64'(wide >> FRAC_BITS);
      if (p == 0) g = OUT_MAX;
      else g = ((64'd1681 * v) << FRAC_BITS) / (10 * p);
    end
    if (g < min_cond) g = min_cond;
    if (g > OUT_MAX) g = OUT_MAX;
    return g[CND_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked = 0;
  end

  assign pending = expected_cond_q.size();

  always @(posedge clk) begin
    logic [CND_W-1:0] want;
    if (!rst_n) begin
      meas_height <= MEAS_RST;
      min_cond <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cond_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", out_conductance_um_s));
        end else begin
          want = expected_cond_q.pop_front();
          checked++;
          if (out_conductance_um_s !== want)
            report_mismatch($sformatf("conductance got %0d expected %0d",
                                      out_conductance_um_s, want));
        end
      end
      if (in_valid && !in_stall)
        expected_cond_q.push_back(predict_conductance(in_canopy_height_mm, in_wind_speed_mm_s));
      if (cfg_we) begin
        if (cfg_idx_t'(cfg_index) == CFG_MEAS_HEIGHT) meas_height <= cfg_data[HGT_W-1:0];
        else if (cfg_idx_t'(cfg_index) == CFG_MIN_COND) min_cond <= cfg_data[CND_W-1:0];
      end
    end
  end

endmodule

[dv/canopy_aerodynamic_conductance_core_tb.sv]
// Testbench top for the canopy conductance core: stimulus, stalls and verdict.
module canopy_aerodynamic_conductance_core_tb import cac_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [HGT_W-1:0]     in_canopy_height_mm;
  logic [SPD_W-1:0]     in_wind_speed_mm_s;
  logic                 out_valid;
  logic                 out_stall;
  logic [CND_W-1:0]     out_conductance_um_s;
  int                   fail_count, pending, checked;
  int                   cycle_count, idle_cycles, items_sent, settings_run;
  logic [HGT_W-1:0]     cur_meas;

  canopy_aerodynamic_conductance_core i_dut (.*);

  cac_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, a long hold-off and a stretch with no stalls
  initial begin
    out_stall = 1'b0;
    cycle_count = 0;
    forever begin
      @(negedge clk);
      cycle_count++;
      if (cycle_count >= 1500 && cycle_count < 1900) out_stall = 1'b1;
      else if (cycle_count >= 3000 && cycle_count < 4000) out_stall = 1'b0;
      else out_stall = ($urandom_range(0, 99) < 10);
    end
  end

  // watchdog on cycles with no transfer
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(logic [HGT_W-1:0] z, logic [CND_W-1:0] gmin);
    wait_drained();
    write_reg(CFG_MEAS_HEIGHT, CFG_W'(z));
    write_reg(CFG_MIN_COND, gmin);
    cur_meas = z;
    settings_run++;
    repeat (4) @(negedge clk);
  endtask

  task automatic send_item(logic [HGT_W-1:0] h, logic [SPD_W-1:0] v, bit gaps);
    if (gaps) begin
      while ($urandom_range(0, 99) < 10) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_canopy_height_mm = h;
    in_wind_speed_mm_s = v;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random(int count, bit gaps);
    logic [HGT_W-1:0] h;
    logic [HGT_W-1:0] lim;
    lim = HGT_W'((98 * int'(cur_meas)) / 100);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: h = HGT_W'($urandom_range(0, 65535));
        1: h = HGT_W'($urandom_range(0, int'(lim)));
        2: h = HGT_W'($urandom_range(0, 255));
        default: h = lim - HGT_W'($urandom_range(0, 3));
      endcase
      send_item(h, SPD_W'($urandom_range(0, 65535)), gaps);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MEAS_HEIGHT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_canopy_height_mm = '0;
    in_wind_speed_mm_s = '0;
    items_sent = 0;
    settings_run = 1;
    cur_meas = MEAS_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, at reset configuration and then at several register settings
    send_item(16'd0, 16'd1000, 1'b0);
    send_item(16'd0, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'd0, 1'b0);
    send_item(16'd1, 16'hFFFF, 1'b0);
    send_item(16'd1, 16'd1, 1'b0);
    send_item(16'd4900, 16'd3000, 1'b0);
    send_item(16'd4899, 16'd3000, 1'b0);
    send_item(16'd500, 16'd2000, 1'b0);
    send_item(16'h5555, 16'hAAAA, 1'b0);
    send_item(16'hAAAA, 16'h5555, 1'b0);
    apply_setting(16'd0, 24'd0);
    send_item(16'd1000, 16'd5000, 1'b0);
    send_item(16'd0, 16'd5000, 1'b0);
    apply_setting(16'd1, 24'd123);
    send_item(16'd1, 16'hFFFF, 1'b0);
    send_item(16'd0, 16'd1, 1'b0);
    apply_setting(16'hFFFF, 24'hFFFFFF);
    send_item(16'd1, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'd0, 1'b0);
    apply_setting(16'hFFFF, 24'd0);
    send_item(16'd1, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'hFFFF, 1'b0);
    send_item(16'd64225, 16'd7, 1'b0);

    // random phases; long pressure hold-off and no-gap stretch fall in here
    send_random(600, 1'b1);
    send_random(400, 1'b0);
    apply_setting(16'd5000, 24'd500);
    send_random(150, 1'b1);
    apply_setting(16'd1, 24'd0);
    send_random(60, 1'b1);
    apply_setting(16'd0, 24'h00FFFF);
    send_random(60, 1'b1);
    apply_setting(HGT_W'($urandom_range(1, 65535)), CFG_W'($urandom_range(0, 16777215)));
    send_random(120, 1'b1);
    apply_setting(HGT_W'($urandom_range(100, 20000)), CFG_W'($urandom_range(0, 2000)));
    send_random(140, 1'b1);

    wait_drained();
    $display("Sent %0d items over %0d register settings; %0d results checked.",
             items_sent, settings_run, checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
